>>> hw/rtl/plc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg
// shared types and constants of the pinned lru page cache
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int unsigned CapacityDef   = 16;
  localparam int unsigned PageIdBitsDef = 24;
  localparam int unsigned PinBitsDef    = 8;
  localparam int unsigned CapRegBits    = 5;
  localparam int unsigned CapRegReset   = 16;

  typedef enum logic [2:0] {
    OP_FETCH_PIN  = 3'd0,
    OP_INSERT_PIN = 3'd1,
    OP_UNPIN      = 3'd2,
    OP_MAKE_DIRTY = 3'd3,
    OP_INVALIDATE = 3'd4,
    OP_FLUSH      = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_UNUSED     = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MISS       = 3'd1,
    ST_CACHED     = 3'd2,
    ST_NOT_CACHED = 3'd3,
    ST_PIN_ERR    = 3'd4,
    ST_FULL       = 3'd5
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic       load;     // capture request
    logic       search;   // register lookup results
    logic       exec;     // apply single-entry operation
    logic       evict;    // drop lru victim
    logic       fill;     // place new entry
    logic       walk_step; // process walk slot
    logic       walk_start;
  } plc_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_e    op;
    logic       hit;
    logic       pinned_hit;
    logic       pin_max;
    logic       dirty_hit;
    logic       full;
    logic       lru_pinned;
    logic       lru_dirty;
    logic       lru_found;
    logic       free_found;
    logic       walk_dirty;
    logic       walk_done;
    logic       walk_more;
  } plc_stat_t;

endpackage

>>> hw/rtl/pinned_lru_page_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinned_lru_page_cache_core
// buffer pool page metadata with pin counts and lru eviction
//
// requests arrive on the s_axis channel, one word each: opcode and page id.
// results leave on m_axis, one or more words per request, tlast on the final.
// a single request passes through the search register stage and the result
// register, which holds each result word.
// an insert into a full pool evicts one entry per pass through the evict and
// search states; a dirty victim's word waits in the result register until the
// next step is known, and each such word that is not the final one is sent on
// its own before that step is looked at again. flush and clear walk the slots
// in order up to the last dirty slot (every slot when none is dirty).
// one request is handled at a time; s_axis_tready is high only when idle.
// a stalled receiver holds the result word and the walk waits on it.
// reset empties the pool and sets capacity_in_use to 16.
// capacity_in_use is at apb byte address 0; the user must write it only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module pinned_lru_page_cache_core import plc_pkg::*; #(
  parameter int unsigned Capacity   = CapacityDef,
  parameter int unsigned PageIdBits = PageIdBitsDef,
  parameter int unsigned PinBits    = PinBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [((3 + PageIdBits + 7) / 8) * 8 - 1:0] s_axis_tdata, // opcode, page_id
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [((4 + PageIdBits + 7) / 8) * 8 - 1:0] m_axis_tdata, // status, writeback_valid, writeback_page
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned OutW = ((4 + PageIdBits + 7) / 8) * 8;

  logic [CapRegBits-1:0] cap_q;
  plc_cmd_t              cmd;
  plc_stat_t             stat;
  logic [PageIdBits-1:0] req_page, lru_page, walk_page, wb_page;
  logic [2:0]            status;
  logic                  wb_valid;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(cap_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapRegBits'(CapRegReset);
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      cap_q <= pwdata[CapRegBits-1:0];
    end
  end

  plc_datapath #(
    .Capacity(Capacity), .PageIdBits(PageIdBits), .PinBits(PinBits)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .op_i(s_axis_tdata[2:0]), .page_i(s_axis_tdata[3 +: PageIdBits]),
    .cap_i(cap_q), .stat_o(stat), .req_page_o(req_page),
    .lru_page_o(lru_page), .walk_page_o(walk_page)
  );

  plc_ctrl #(.PageIdBits(PageIdBits)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_o(status), .wb_valid_o(wb_valid), .wb_page_o(wb_page),
    .last_o(m_axis_tlast), .cmd_o(cmd), .stat_i(stat),
    .req_page_i(req_page), .lru_page_i(lru_page), .walk_page_i(walk_page)
  );

  assign m_axis_tdata = OutW'({wb_page, wb_valid, status});

`ifndef NO_ASSERTIONS
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("result while idle");
  a_wb_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[3]) |-> m_axis_tdata[4 +: PageIdBits] == '0)
    else $error("page without writeback");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[3] && !m_axis_tlast) |-> m_axis_tdata[2:0] == 3'd0)
    else $error("bad writeback status");
`endif

endmodule

>>> hw/rtl/plc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_datapath
// entry table, lookup, lru ranks and slot walk
// ----------------------------------------------------------------------------
module plc_datapath import plc_pkg::*; #(
  parameter int unsigned Capacity   = CapacityDef,
  parameter int unsigned PageIdBits = PageIdBitsDef,
  parameter int unsigned PinBits    = PinBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  plc_cmd_t              cmd_i,
  input  logic [2:0]            op_i,
  input  logic [PageIdBits-1:0] page_i,
  input  logic [CapRegBits-1:0] cap_i,
  output plc_stat_t             stat_o,
  output logic [PageIdBits-1:0] req_page_o,
  output logic [PageIdBits-1:0] lru_page_o,
  output logic [PageIdBits-1:0] walk_page_o
);

  localparam int unsigned SlotBits = $clog2(Capacity);
  localparam int unsigned OccBits  = $clog2(Capacity + 1);

  logic [Capacity-1:0]   valid_q;
  logic [PageIdBits-1:0] page_q [Capacity];
  logic [PinBits-1:0]    pins_q [Capacity];
  logic [Capacity-1:0]   dirty_q;
  logic [SlotBits-1:0]   rank_q [Capacity];
  logic [OccBits-1:0]    occ_q;

  logic [2:0]            op_q;
  logic [PageIdBits-1:0] req_q;
  logic [SlotBits-1:0]   hit_slot_q, lru_slot_q, free_slot_q, walk_q;
  logic                  hit_q, lru_found_q, free_found_q;
  logic [OccBits-1:0]    eff_cap;
  logic                  walk_more_c;

  // combinational lookup
  logic [SlotBits-1:0]   hit_slot_c, lru_slot_c, free_slot_c;
  logic                  hit_c, lru_found_c, free_found_c;

  always_comb begin
    hit_c = 1'b0;
    hit_slot_c = '0;
    lru_found_c = 1'b0;
    lru_slot_c = '0;
    free_found_c = 1'b0;
    free_slot_c = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (valid_q[i] && page_q[i] == req_q) begin
        hit_c = 1'b1;
        hit_slot_c = SlotBits'(i);
      end
      if (valid_q[i] && rank_q[i] == '0) begin
        lru_found_c = 1'b1;
        lru_slot_c = SlotBits'(i);
      end
      if (!valid_q[i]) begin
        free_found_c = 1'b1;
        free_slot_c = SlotBits'(i);
      end
    end
  end

  always_comb begin
    if (cap_i == '0) begin
      eff_cap = OccBits'(1);
    end else if (32'(cap_i) > Capacity) begin
      eff_cap = OccBits'(Capacity);
    end else begin
      eff_cap = OccBits'(cap_i);
    end
  end

  assign stat_o.op         = opcode_e'(op_q);
  assign stat_o.hit        = hit_q;
  assign stat_o.pinned_hit = pins_q[hit_slot_q] != '0;
  assign stat_o.pin_max    = &pins_q[hit_slot_q];
  assign stat_o.dirty_hit  = dirty_q[hit_slot_q];
  assign stat_o.full       = occ_q >= eff_cap;
  assign stat_o.lru_pinned = pins_q[lru_slot_q] != '0;
  assign stat_o.lru_dirty  = dirty_q[lru_slot_q];
  assign stat_o.lru_found  = lru_found_q;
  assign stat_o.free_found = free_found_q;
  assign stat_o.walk_dirty = valid_q[walk_q] && dirty_q[walk_q];
  assign stat_o.walk_done  = 32'(walk_q) == Capacity - 1;
  assign stat_o.walk_more  = walk_more_c;

  always_comb begin
    walk_more_c = 1'b0;
    for (int i = 0; i < Capacity; i++) begin
      if (32'(i) > 32'(walk_q) && valid_q[i] && dirty_q[i]) walk_more_c = 1'b1;
    end
  end

  assign req_page_o  = req_q;
  assign lru_page_o  = page_q[lru_slot_q];
  assign walk_page_o = page_q[walk_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      req_q <= page_i;
    end
    if (cmd_i.search) begin
      hit_q        <= hit_c;
      hit_slot_q   <= hit_slot_c;
      lru_found_q  <= lru_found_c;
      lru_slot_q   <= lru_slot_c;
      free_found_q <= free_found_c;
      free_slot_q  <= free_slot_c;
    end
    if (cmd_i.walk_start) begin
      walk_q <= '0;
    end else if (cmd_i.walk_step && !stat_o.walk_done) begin
      walk_q <= walk_q + 1'b1;
    end
  end

  // entry table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else begin
      if (cmd_i.exec) begin
        case (opcode_e'(op_q))
          OP_FETCH_PIN: begin
            for (int i = 0; i < Capacity; i++) begin
              if (valid_q[i] && SlotBits'(i) != hit_slot_q && rank_q[i] > rank_q[hit_slot_q])
                rank_q[i] <= rank_q[i] - 1'b1;
            end
            rank_q[hit_slot_q] <= SlotBits'(occ_q - 1'b1);
            pins_q[hit_slot_q] <= pins_q[hit_slot_q] + 1'b1;
          end
          OP_UNPIN:      pins_q[hit_slot_q] <= pins_q[hit_slot_q] - 1'b1;
          OP_MAKE_DIRTY: dirty_q[hit_slot_q] <= 1'b1;
          OP_INVALIDATE: begin
            for (int i = 0; i < Capacity; i++) begin
              if (valid_q[i] && rank_q[i] > rank_q[hit_slot_q])
                rank_q[i] <= rank_q[i] - 1'b1;
            end
            valid_q[hit_slot_q] <= 1'b0;
            occ_q <= occ_q - 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd_i.evict) begin
        for (int i = 0; i < Capacity; i++) begin
          if (valid_q[i] && rank_q[i] != '0) rank_q[i] <= rank_q[i] - 1'b1;
        end
        valid_q[lru_slot_q] <= 1'b0;
        occ_q <= occ_q - 1'b1;
      end
      if (cmd_i.fill) begin
        valid_q[free_slot_q] <= 1'b1;
        page_q[free_slot_q]  <= req_q;
        pins_q[free_slot_q]  <= PinBits'(1);
        dirty_q[free_slot_q] <= 1'b0;
        rank_q[free_slot_q]  <= SlotBits'(occ_q);
        occ_q <= occ_q + 1'b1;
      end
      if (cmd_i.walk_step) begin
        dirty_q[walk_q] <= 1'b0;
        // no dirty slot left ahead, so the whole pool can go
        if (opcode_e'(op_q) == OP_CLEAR && (stat_o.walk_done || !walk_more_c)) begin
          valid_q <= '0;
          occ_q   <= '0;
        end
      end
    end
  end

endmodule

>>> hw/rtl/plc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_ctrl
// request sequencer and result word register
// ----------------------------------------------------------------------------
module plc_ctrl import plc_pkg::*; #(
  parameter int unsigned PageIdBits = PageIdBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic                  wb_valid_o,
  output logic [PageIdBits-1:0] wb_page_o,
  output logic                  last_o,
  output plc_cmd_t              cmd_o,
  input  plc_stat_t             stat_i,
  input  logic [PageIdBits-1:0] req_page_i,
  input  logic [PageIdBits-1:0] lru_page_i,
  input  logic [PageIdBits-1:0] walk_page_i
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_EXEC   = 6'b000100,
    S_EVICT  = 6'b001000,
    S_WALK   = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   ret_q, ret_d; // return to search after output
  logic   ov_q, ov_d, ret_walk_q, ret_walk_d;
  logic   held_q, held_d; // write-back word waiting in the result register
  logic   held_out;       // next insert step emits a word of its own
  logic [2:0]            st_q, st_d;
  logic                  wv_q, wv_d, last_q, last_d;
  logic [PageIdBits-1:0] wp_q, wp_d;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  assign wb_valid_o  = wv_q;
  assign wb_page_o   = wp_q;
  assign last_o      = last_q;

  assign held_out = (stat_i.full && stat_i.lru_found) ?
                    (stat_i.lru_pinned || stat_i.lru_dirty) : !stat_i.free_found;

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    ret_walk_d = ret_walk_q;
    ov_d = ov_q;
    held_d = held_q;
    st_d = st_q; wv_d = wv_q; wp_d = wp_q; last_d = last_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        cmd_o.walk_start = 1'b1;
        state_d = (stat_i.op == OP_FLUSH || stat_i.op == OP_CLEAR) ? S_WALK : S_EXEC;
      end
      S_EXEC: begin
        st_d = ST_OK; wv_d = 1'b0; wp_d = '0; last_d = 1'b1;
        ret_d = 1'b0; ret_walk_d = 1'b0;
        state_d = S_OUT; ov_d = 1'b1;
        case (stat_i.op)
          OP_FETCH_PIN: begin
            if (!stat_i.hit) st_d = ST_MISS;
            else if (stat_i.pin_max) st_d = ST_PIN_ERR;
            else cmd_o.exec = 1'b1;
          end
          OP_INSERT_PIN: begin
            if (stat_i.hit) begin
              st_d = ST_CACHED;
            end else if (held_q && held_out) begin
              // send the held word, then look at the same step again
              wv_d = 1'b1; wp_d = wp_q; last_d = 1'b0;
              held_d = 1'b0; ret_d = 1'b1;
            end else if (stat_i.full && stat_i.lru_found) begin
              if (stat_i.lru_pinned) begin
                st_d = ST_FULL;
              end else begin
                cmd_o.evict = 1'b1;
                ov_d = 1'b0;
                state_d = S_EVICT;
                if (stat_i.lru_dirty) begin
                  wv_d = 1'b1; wp_d = lru_page_i; last_d = 1'b0; held_d = 1'b1;
                end else if (held_q) begin
                  wv_d = 1'b1; wp_d = wp_q; last_d = 1'b0;
                end
              end
            end else if (!stat_i.free_found) begin
              st_d = ST_FULL;
            end else begin
              cmd_o.fill = 1'b1;
              if (held_q) begin
                wv_d = 1'b1; wp_d = wp_q; held_d = 1'b0;
              end
            end
          end
          OP_UNPIN: begin
            if (!stat_i.hit) st_d = ST_NOT_CACHED;
            else if (!stat_i.pinned_hit) st_d = ST_PIN_ERR;
            else cmd_o.exec = 1'b1;
          end
          OP_MAKE_DIRTY: begin
            if (!stat_i.hit) st_d = ST_NOT_CACHED;
            else cmd_o.exec = 1'b1;
          end
          OP_INVALIDATE: begin
            if (!stat_i.hit) st_d = ST_NOT_CACHED;
            else if (stat_i.pinned_hit) st_d = ST_PIN_ERR;
            else begin
              cmd_o.exec = 1'b1;
              wv_d = stat_i.dirty_hit;
              wp_d = stat_i.dirty_hit ? req_page_i : '0;
            end
          end
          default: ;
        endcase
      end
      S_EVICT: begin
        // re-search after an eviction, keeping earlier word flags
        state_d = S_SEARCH;
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        st_d = ST_OK; ret_d = 1'b0; ret_walk_d = 1'b0;
        if (stat_i.walk_dirty) begin
          wv_d = 1'b1; wp_d = walk_page_i;
          last_d = !stat_i.walk_more;
          ov_d = 1'b1; state_d = S_OUT;
          ret_walk_d = stat_i.walk_more && !stat_i.walk_done;
        end else if (stat_i.walk_done || !stat_i.walk_more) begin
          if (!stat_i.walk_done) state_d = S_WALK;
          else begin
            wv_d = 1'b0; wp_d = '0; last_d = 1'b1;
            ov_d = 1'b1; state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          if (ret_q) state_d = S_SEARCH;
          else if (ret_walk_q) state_d = S_WALK;
          else state_d = last_q ? S_IDLE : S_WALK;
          if (last_q && !ret_q) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
      ret_q <= 1'b0;
      ret_walk_q <= 1'b0;
      held_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
      ret_q <= ret_d;
      ret_walk_q <= ret_walk_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) wv_q <= 1'b0;
    else wv_q <= wv_d;
    st_q <= st_d; wp_q <= wp_d; last_q <= last_d;
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pinned lru page cache core
//
// drives random and directed requests (fetch, insert, unpin, dirty,
// invalidate, flush, clear, unused opcode) over the stream input, predicts every result word
// with a local model of the pool and checks words in order on the output.
// capacity is reprogrammed over apb between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb import plc_pkg::*; ();

  localparam int NSLOT = 16;
  localparam int PIN_MAX = 255;
  localparam int WDOG = 20000;
  localparam int RING = 64;

  typedef struct packed {
    status_e     status;
    logic        wb_valid;
    logic [23:0] wb_page;
    logic        last;
  } pool_word_t;

  class pool_scoreboard;
    bit          valid[NSLOT];
    logic [23:0] page[NSLOT];
    int          pins[NSLOT];
    bit          dirty[NSLOT];
    int          rank[NSLOT];
    int          occ;
    int          cap;
    pool_word_t  exp_ring[RING];
    int          wr_ptr;
    int          rd_ptr;
    int          errors;
    int          words_seen;

    function new();
      occ = 0;
      cap = 16;
      errors = 0;
      words_seen = 0;
      wr_ptr = 0;
      rd_ptr = 0;
      foreach (valid[i]) valid[i] = 0;
    endfunction

    function int outstanding();
      return wr_ptr - rd_ptr;
    endfunction

    function void put(status_e st, bit wv, logic [23:0] pg, bit lst);
      pool_word_t w;
      w.status = st;
      w.wb_valid = wv;
      w.wb_page = wv ? pg : 24'd0;
      w.last = lst;
      exp_ring[wr_ptr % RING] = w;
      wr_ptr++;
    endfunction

    function void mark_last();
      exp_ring[(wr_ptr - 1) % RING].last = 1'b1;
    endfunction

    function int find(logic [23:0] pg);
      for (int i = 0; i < NSLOT; i++) if (valid[i] && page[i] == pg) return i;
      return -1;
    endfunction

    function void drop(int s);
      for (int i = 0; i < NSLOT; i++)
        if (valid[i] && i != s && rank[i] > rank[s]) rank[i]--;
      valid[s] = 0;
      if (occ > 0) occ--;
    endfunction

    function void walk_all(bit clr);
      int n;
      n = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (valid[i] && dirty[i]) begin
          put(ST_OK, 1, page[i], 0);
          dirty[i] = 0;
          n++;
        end
        if (clr) valid[i] = 0;
      end
      if (clr) occ = 0;
      if (n == 0) put(ST_OK, 0, 0, 1);
      else mark_last();
    endfunction

    function void note_request(opcode_e op, logic [23:0] pg);
      int s, n, ec, best, f;
      s = find(pg);
      case (op)
        OP_FETCH_PIN: begin
          if (s < 0) put(ST_MISS, 0, 0, 1);
          else if (pins[s] >= PIN_MAX) put(ST_PIN_ERR, 0, 0, 1);
          else begin
            pins[s]++;
            for (int i = 0; i < NSLOT; i++)
              if (valid[i] && i != s && rank[i] > rank[s]) rank[i]--;
            rank[s] = occ > 0 ? occ - 1 : 0;
            put(ST_OK, 0, 0, 1);
          end
        end
        OP_INSERT_PIN: begin
          if (s >= 0) begin
            put(ST_CACHED, 0, 0, 1);
            return;
          end
          n = 0;
          ec = cap < 1 ? 1 : (cap > NSLOT ? NSLOT : cap);
          while (occ >= ec) begin
            best = -1;
            for (int i = 0; i < NSLOT; i++)
              if (valid[i] && (best < 0 || rank[i] < rank[best])) best = i;
            if (best < 0) break;
            if (pins[best] != 0) begin
              put(ST_FULL, 0, 0, 1);
              return;
            end
            if (dirty[best]) begin
              put(ST_OK, 1, page[best], 0);
              n++;
            end
            drop(best);
          end
          f = -1;
          for (int i = NSLOT - 1; i >= 0; i--) if (!valid[i]) f = i;
          if (f < 0) begin
            put(ST_FULL, 0, 0, 1);
            return;
          end
          valid[f] = 1;
          page[f] = pg;
          pins[f] = 1;
          dirty[f] = 0;
          rank[f] = occ;
          occ++;
          if (n == 0) put(ST_OK, 0, 0, 1);
          else mark_last();
        end
        OP_UNPIN: begin
          if (s < 0) put(ST_NOT_CACHED, 0, 0, 1);
          else if (pins[s] == 0) put(ST_PIN_ERR, 0, 0, 1);
          else begin
            pins[s]--;
            put(ST_OK, 0, 0, 1);
          end
        end
        OP_MAKE_DIRTY: begin
          if (s < 0) put(ST_NOT_CACHED, 0, 0, 1);
          else begin
            dirty[s] = 1;
            put(ST_OK, 0, 0, 1);
          end
        end
        OP_INVALIDATE: begin
          if (s < 0) put(ST_NOT_CACHED, 0, 0, 1);
          else if (pins[s] != 0) put(ST_PIN_ERR, 0, 0, 1);
          else begin
            put(ST_OK, dirty[s], pg, 1);
            drop(s);
          end
        end
        OP_FLUSH: walk_all(0);
        OP_CLEAR: walk_all(1);
        default: put(ST_OK, 0, 0, 1);
      endcase
    endfunction

    function void check_word(pool_word_t got);
      pool_word_t exp;
      words_seen++;
      if (wr_ptr == rd_ptr) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      exp = exp_ring[rd_ptr % RING];
      rd_ptr++;
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.wb_valid !== exp.wb_valid) begin
        $display("%0t: wb_valid exp %0b got %0b", $time, exp.wb_valid, got.wb_valid);
        errors++;
      end
      if (got.wb_page !== exp.wb_page) begin
        $display("%0t: wb_page exp %h got %h", $time, exp.wb_page, got.wb_page);
        errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t: last exp %0b got %0b", $time, exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 0;  // opcode, page_id
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;      // status, writeback_valid, writeback_page
  logic        m_axis_tlast;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [1:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  pool_scoreboard sb;
  int idle_cycles;
  int items_sent;
  bit rx_on;
  logic [23:0] ids[8];

  pinned_lru_page_cache_core dut (.*);

  initial forever #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready
        || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver with random stalls
  initial begin
    pool_word_t w;
    int gap;
    forever begin
      @(posedge clk_i);
      if (rx_on) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        repeat (gap) @(posedge clk_i);
        m_axis_tready <= 1;
        do @(posedge clk_i); while (!m_axis_tvalid);
        w.status = status_e'(m_axis_tdata[2:0]);
        w.wb_valid = m_axis_tdata[3];
        w.wb_page = m_axis_tdata[27:4];
        w.last = m_axis_tlast;
        sb.check_word(w);
        m_axis_tready <= 0;
      end
    end
  end

  task automatic send_req(opcode_e op, logic [23:0] pg, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {5'd0, pg, op};
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, pg);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [4:0] c);
    drain();
    psel <= 1;
    pwrite <= 1;
    paddr <= 2'd0;
    pwdata <= {27'd0, c};
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    sb.cap = c;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  function automatic opcode_e pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return OP_FETCH_PIN;
    if (r < 50) return OP_INSERT_PIN;
    if (r < 68) return OP_UNPIN;
    if (r < 80) return OP_MAKE_DIRTY;
    if (r < 90) return OP_INVALIDATE;
    if (r < 94) return OP_FLUSH;
    if (r < 97) return OP_CLEAR;
    return OP_UNUSED;
  endfunction

  initial begin
    logic [23:0] pg;
    sb = new();
    idle_cycles = 0;
    items_sent = 0;
    rx_on = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    rx_on = 1;

    // directed: extremes and special cases
    set_capacity(5'd2);
    send_req(OP_FETCH_PIN, 24'hFFFFFF, 0);
    send_req(OP_UNPIN, 24'h000000, 0);
    send_req(OP_INSERT_PIN, 24'h000000, 0);
    send_req(OP_INSERT_PIN, 24'h000000, 1);
    send_req(OP_INSERT_PIN, 24'hFFFFFF, 0);
    send_req(OP_INSERT_PIN, 24'h555555, 0);
    send_req(OP_INVALIDATE, 24'h000000, 0);
    send_req(OP_MAKE_DIRTY, 24'h000000, 0);
    send_req(OP_UNPIN, 24'h000000, 0);
    send_req(OP_UNPIN, 24'h000000, 0);
    send_req(OP_UNPIN, 24'hFFFFFF, 2);
    send_req(OP_MAKE_DIRTY, 24'hFFFFFF, 0);
    send_req(OP_INSERT_PIN, 24'hAAAAAA, 0);
    send_req(OP_FLUSH, 24'h123456, 0);
    send_req(OP_FETCH_PIN, 24'h000000, 0);
    send_req(OP_UNPIN, 24'hAAAAAA, 0);
    send_req(OP_UNPIN, 24'h000000, 0);
    send_req(OP_MAKE_DIRTY, 24'hAAAAAA, 0);
    send_req(OP_INVALIDATE, 24'hAAAAAA, 0);
    send_req(OP_UNUSED, 24'h0F0F0F, 0);
    send_req(OP_CLEAR, 24'h000000, 0);
    set_capacity(5'd1);
    send_req(OP_INSERT_PIN, 24'h000001, 0);
    send_req(OP_INSERT_PIN, 24'h000002, 0);
    send_req(OP_FETCH_PIN, 24'h000001, 0);
    send_req(OP_CLEAR, 24'h000000, 0);

    // random phases over several capacities, out-of-range ones included
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_capacity(5'd16);
        1: set_capacity(5'd1);
        2: set_capacity(5'd0);
        3: set_capacity(5'd31);
        default: set_capacity(5'($urandom_range(1, 16)));
      endcase
      for (int k = 0; k < 8; k++) ids[k] = 24'($urandom);
      for (int j = 0; j < 26; j++) begin
        if ($urandom_range(0, 9) == 0) pg = 24'($urandom);
        else pg = ids[$urandom_range(0, 7)];
        send_req(($urandom_range(0, 3) == 0) ? pick_op() : pick_op(), pg,
                 ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6));
      end
    end

    drain();
    $display("requests sent: %0d, result words checked: %0d", items_sent,
             sb.words_seen);
    $display("covered capacities 0, 1, 16, 31 and random, evictions, flush and clear");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/plc_pkg.sv
hw/rtl/plc_datapath.sv
hw/rtl/plc_ctrl.sv
hw/rtl/pinned_lru_page_cache_core.sv
dv/tb.sv
